FILE: rtl/core/thhl_pkg.sv
package thhl_pkg;

    localparam int HIST_DEPTH = 256;
    localparam int NUM_VARS   = 8;
    localparam int NUM_MARKS  = 4;

    localparam int SLOT_W    = $clog2(HIST_DEPTH);
    localparam int VAR_W     = $clog2(NUM_VARS);
    localparam int MRK_W     = $clog2(NUM_MARKS);
    localparam int MIDX_W    = VAR_W + MRK_W;
    localparam int VADDR_W   = VAR_W + SLOT_W;
    localparam int CLR_DEPTH = NUM_VARS * HIST_DEPTH;
    localparam int NUM_MIDX  = NUM_VARS * NUM_MARKS;

    // request codes
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_STORE  = 2'd1;
    localparam logic [1:0] REQ_QVAL   = 2'd2;
    localparam logic [1:0] REQ_QGRAD  = 2'd3;

    // fixed point
    localparam logic signed [63:0] SAT_LIM = 64'sh2000_0000_0000_0000;
    localparam logic signed [63:0] DIV_LIM = 64'sh0000_0100_0000_0000;
    localparam logic signed [63:0] K_ONE   = 64'sd65536;
    localparam logic signed [63:0] K_TWO   = 64'sd131072;
    localparam logic signed [63:0] K_THREE = 64'sd196608;
    localparam logic signed [63:0] K_FOUR  = 64'sd262144;
    localparam logic signed [63:0] K_SIX   = 64'sd393216;

    // iterative arithmetic unit
    localparam int DIV_DW    = 41;
    localparam int DIV_NW    = DIV_DW + 16;
    localparam int CNT_W     = 6;
    localparam int MUL_STEPS = 4;
    localparam logic [CNT_W-1:0] MUL_DONE = CNT_W'(MUL_STEPS + 2);
    localparam logic [CNT_W-1:0] DIV_DONE = CNT_W'(DIV_NW + 1);

    // micro-program addresses
    localparam int UPC_W = 6;
    localparam logic [UPC_W-1:0] UPC_COMMON  = 6'd0;
    localparam logic [UPC_W-1:0] UPC_GRAD    = 6'd20;
    localparam logic [UPC_W-1:0] UPC_SW_VAL  = 6'd35;
    localparam logic [UPC_W-1:0] UPC_SW_GRAD = 6'd38;
    localparam logic [UPC_W-1:0] UPC_ZI_VAL  = 6'd39;
    localparam logic [UPC_W-1:0] UPC_ZI_GRAD = 6'd40;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_HIT_RD, ST_HIT_CHK, ST_WRITE,
        ST_W1_RD, ST_W1_CHK, ST_W2_RD, ST_W2_CHK, ST_LD_RD, ST_LD_CAP,
        ST_DECIDE, ST_ISSUE, ST_WAIT, ST_DONE
    } t_state;

    typedef enum logic [1:0] {RD_OFF, RD_K, RD_K1} t_rd_sel;

    typedef enum logic [1:0] {UK_ADD, UK_SUB, UK_MUL, UK_DIV} t_uop_kind;

    typedef enum logic [4:0] {
        S_ZERO, S_T, S_X0, S_X1, S_Y0, S_Y1, S_G0, S_G1, S_H,
        S_A, S_B, S_C, S_U, S_U2, S_U3, S_RES,
        S_K1, S_K2, S_K3, S_K4, S_K6
    } t_src;

    typedef enum logic [2:0] {D_A, D_B, D_C, D_U, D_U2, D_U3, D_RES} t_dst;

    typedef struct packed {
        t_uop_kind kind;
        t_dst      dst;
        t_src      sa;
        t_src      sb;
        logic      last;
        logic      br;
    } t_uop;

    typedef struct packed {
        logic             accept;
        logic             clear_step;
        logic             wr_item;
        t_rd_sel          rd_sel;
        logic             k_init;
        logic             k1_inc;
        logic             k_from_k1;
        logic             k_dec;
        logic             k1_from_k;
        logic             cap_lo;
        logic             cap_hi;
        logic             set_hit;
        logic             mark_wr;
        logic             alu_start;
        logic [UPC_W-1:0] pc;
        logic             out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic is_write;
        logic is_grad;
        logic hit;
        logic w1_go;
        logic w2_go;
        logic sw;
        logic zi;
        logic alu_busy;
        logic alu_done;
    } t_dp_stat;

    function automatic logic signed [63:0] sat61(input logic signed [63:0] x);
        if (x > SAT_LIM) return SAT_LIM;
        if (x < -SAT_LIM) return -SAT_LIM;
        return x;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7fff_ffff;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    // Hermite evaluation sequence: common head, value tail, gradient tail,
    // switch extrapolation and zero interval
    function automatic t_uop uop_rom(input logic [UPC_W-1:0] pc);
        t_uop u;
        u = '{UK_ADD, D_RES, S_ZERO, S_ZERO, 1'b1, 1'b0};
        case (pc)
            6'd0:  u = '{UK_SUB, D_A,   S_T,   S_X0,   1'b0, 1'b0};
            6'd1:  u = '{UK_DIV, D_U,   S_A,   S_H,    1'b0, 1'b0};
            6'd2:  u = '{UK_MUL, D_U2,  S_U,   S_U,    1'b0, 1'b0};
            6'd3:  u = '{UK_MUL, D_U3,  S_U2,  S_U,    1'b0, 1'b1};
            6'd4:  u = '{UK_MUL, D_A,   S_K3,  S_U2,   1'b0, 1'b0};
            6'd5:  u = '{UK_MUL, D_B,   S_K2,  S_U3,   1'b0, 1'b0};
            6'd6:  u = '{UK_SUB, D_A,   S_A,   S_B,    1'b0, 1'b0};
            6'd7:  u = '{UK_SUB, D_B,   S_Y1,  S_Y0,   1'b0, 1'b0};
            6'd8:  u = '{UK_MUL, D_RES, S_B,   S_A,    1'b0, 1'b0};
            6'd9:  u = '{UK_ADD, D_RES, S_Y0,  S_RES,  1'b0, 1'b0};
            6'd10: u = '{UK_MUL, D_A,   S_K2,  S_U2,   1'b0, 1'b0};
            6'd11: u = '{UK_SUB, D_A,   S_U3,  S_A,    1'b0, 1'b0};
            6'd12: u = '{UK_ADD, D_A,   S_A,   S_U,    1'b0, 1'b0};
            6'd13: u = '{UK_MUL, D_B,   S_H,   S_G0,   1'b0, 1'b0};
            6'd14: u = '{UK_MUL, D_B,   S_B,   S_A,    1'b0, 1'b0};
            6'd15: u = '{UK_ADD, D_RES, S_RES, S_B,    1'b0, 1'b0};
            6'd16: u = '{UK_SUB, D_A,   S_U3,  S_U2,   1'b0, 1'b0};
            6'd17: u = '{UK_MUL, D_B,   S_H,   S_G1,   1'b0, 1'b0};
            6'd18: u = '{UK_MUL, D_B,   S_B,   S_A,    1'b0, 1'b0};
            6'd19: u = '{UK_ADD, D_RES, S_RES, S_B,    1'b1, 1'b0};
            6'd20: u = '{UK_SUB, D_B,   S_Y1,  S_Y0,   1'b0, 1'b0};
            6'd21: u = '{UK_DIV, D_C,   S_B,   S_H,    1'b0, 1'b0};
            6'd22: u = '{UK_SUB, D_A,   S_U,   S_U2,   1'b0, 1'b0};
            6'd23: u = '{UK_MUL, D_A,   S_K6,  S_A,    1'b0, 1'b0};
            6'd24: u = '{UK_MUL, D_RES, S_C,   S_A,    1'b0, 1'b0};
            6'd25: u = '{UK_MUL, D_A,   S_K3,  S_U2,   1'b0, 1'b0};
            6'd26: u = '{UK_MUL, D_B,   S_K4,  S_U,    1'b0, 1'b0};
            6'd27: u = '{UK_SUB, D_B,   S_A,   S_B,    1'b0, 1'b0};
            6'd28: u = '{UK_ADD, D_B,   S_B,   S_K1,   1'b0, 1'b0};
            6'd29: u = '{UK_MUL, D_B,   S_G0,  S_B,    1'b0, 1'b0};
            6'd30: u = '{UK_ADD, D_RES, S_RES, S_B,    1'b0, 1'b0};
            6'd31: u = '{UK_MUL, D_B,   S_K2,  S_U,    1'b0, 1'b0};
            6'd32: u = '{UK_SUB, D_B,   S_A,   S_B,    1'b0, 1'b0};
            6'd33: u = '{UK_MUL, D_B,   S_G1,  S_B,    1'b0, 1'b0};
            6'd34: u = '{UK_ADD, D_RES, S_RES, S_B,    1'b1, 1'b0};
            6'd35: u = '{UK_SUB, D_A,   S_T,   S_X1,   1'b0, 1'b0};
            6'd36: u = '{UK_MUL, D_A,   S_A,   S_G1,   1'b0, 1'b0};
            6'd37: u = '{UK_ADD, D_RES, S_Y1,  S_A,    1'b1, 1'b0};
            6'd38: u = '{UK_ADD, D_RES, S_G1,  S_ZERO, 1'b1, 1'b0};
            6'd39: u = '{UK_ADD, D_RES, S_Y0,  S_ZERO, 1'b1, 1'b0};
            6'd40: u = '{UK_ADD, D_RES, S_G0,  S_ZERO, 1'b1, 1'b0};
            default: u = '{UK_ADD, D_RES, S_ZERO, S_ZERO, 1'b1, 1'b0};
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/core/thhl_ctrl.sv
module thhl_ctrl import thhl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state           r_state, n_state;
    logic [UPC_W-1:0] r_pc, n_pc;
    logic             r_out_valid, n_out_valid;
    t_uop             w_uop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_pc        <= UPC_COMMON;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_pc         = r_pc;
        w_uop        = uop_rom(r_pc);
        o_cmd        = '0;
        o_cmd.rd_sel = RD_OFF;
        o_cmd.pc     = r_pc;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_HIT_RD;
                end
            end
            ST_HIT_RD: n_state = ST_HIT_CHK;
            ST_HIT_CHK: begin
                if (i_stat.is_write) begin
                    n_state = ST_WRITE;
                end else if (i_stat.hit) begin
                    o_cmd.cap_lo  = 1'b1;
                    o_cmd.set_hit = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    o_cmd.k_init = 1'b1;
                    n_state      = ST_W1_RD;
                end
            end
            ST_WRITE: begin
                o_cmd.wr_item = 1'b1;
                n_state       = ST_DONE;
            end
            ST_W1_RD: begin
                o_cmd.rd_sel = RD_K1;
                n_state      = ST_W1_CHK;
            end
            ST_W1_CHK: begin
                if (i_stat.w1_go) begin
                    o_cmd.k1_inc = 1'b1;
                    n_state      = ST_W1_RD;
                end else begin
                    o_cmd.k_from_k1 = 1'b1;
                    n_state         = ST_W2_RD;
                end
            end
            ST_W2_RD: begin
                o_cmd.rd_sel = RD_K;
                n_state      = ST_W2_CHK;
            end
            ST_W2_CHK: begin
                if (i_stat.w2_go) begin
                    o_cmd.k_dec = 1'b1;
                    n_state     = ST_W2_RD;
                end else begin
                    o_cmd.cap_lo    = 1'b1;
                    o_cmd.k1_from_k = 1'b1;
                    n_state         = ST_LD_RD;
                end
            end
            ST_LD_RD: begin
                o_cmd.rd_sel = RD_K1;
                n_state      = ST_LD_CAP;
            end
            ST_LD_CAP: begin
                o_cmd.cap_hi  = 1'b1;
                o_cmd.mark_wr = 1'b1;
                n_state       = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_stat.sw) n_pc = i_stat.is_grad ? UPC_SW_GRAD : UPC_SW_VAL;
                else if (i_stat.zi) n_pc = i_stat.is_grad ? UPC_ZI_GRAD : UPC_ZI_VAL;
                else n_pc = UPC_COMMON;
                n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                o_cmd.alu_start = 1'b1;
                n_state         = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_stat.alu_done) begin
                    if (w_uop.last) begin
                        n_state = ST_DONE;
                    end else begin
                        n_pc    = (w_uop.br && i_stat.is_grad) ? UPC_GRAD : r_pc + 1'b1;
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_DONE: begin
                if (!(r_out_valid && i_out_stall)) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = (r_out_valid && i_out_stall) || o_cmd.out_load;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/thhl_dpath.sv
module thhl_dpath import thhl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [1:0]         i_req_type,
    input  logic [2:0]         i_var_index,
    input  logic [1:0]         i_marker_index,
    input  logic [31:0]        i_when,
    input  logic signed [31:0] i_sample_value,
    input  logic signed [31:0] i_sample_slope,
    output logic signed [31:0] o_answer,
    output logic               o_lag_too_large
);

    // item registers
    logic [1:0]         r_req;
    logic [VAR_W-1:0]   r_var;
    logic [MRK_W-1:0]   r_mrk;
    logic [31:0]        r_t;
    logic signed [31:0] r_sv, r_sg;

    // ring control
    logic [VADDR_W-1:0] r_clr;
    logic [SLOT_W-1:0]  r_wslot;
    logic [SLOT_W-1:0]  r_marks [NUM_MIDX];
    logic [SLOT_W-1:0]  r_k, r_k1;
    logic [MIDX_W-1:0]  w_midx;
    logic [SLOT_W-1:0]  w_wr_slot, w_rd_slot, w_offp;

    // sample memories
    logic [31:0]        m_time  [HIST_DEPTH];
    logic [31:0]        m_val   [CLR_DEPTH];
    logic [31:0]        m_slope [CLR_DEPTH];
    logic [31:0]        r_time_q, r_val_q, r_slope_q;

    // bracketing pair
    logic [31:0]        r_x0, r_x1;
    logic signed [31:0] r_y0, r_y1, r_g0, r_g1;
    logic signed [32:0] r_h;
    logic               r_flag, r_hit;

    // arithmetic unit
    logic               r_busy;
    t_uop               r_uop, w_uop;
    logic signed [63:0] r_opa, r_opb;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_neg;
    logic [63:0]        r_ma, r_mb, r_pp;
    logic [1:0]         r_psh, w_step;
    logic [31:0]        w_pa, w_pb;
    logic [63:0]        w_prod, w_mmag;
    logic [127:0]       r_acc;
    logic [DIV_NW-1:0]  r_dnum;
    logic [DIV_DW-1:0]  r_dden, r_drem;
    logic               r_dzero;
    logic [DIV_DW:0]    w_dsh, w_dtrial;
    logic signed [63:0] w_ca, w_cb, w_alu_res;
    logic [63:0]        w_dmag_a, w_dmag_b;
    logic               w_alu_done;
    logic signed [63:0] r_a, r_b, r_c, r_u, r_u2, r_u3, r_res;

    function automatic logic signed [63:0] clamp40(input logic signed [63:0] x);
        if (x > DIV_LIM) return DIV_LIM;
        if (x < -DIV_LIM) return -DIV_LIM;
        return x;
    endfunction

    function automatic logic signed [63:0] src_val(input t_src s);
        case (s)
            S_ZERO:  return '0;
            S_T:     return 64'(r_t);
            S_X0:    return 64'(r_x0);
            S_X1:    return 64'(r_x1);
            S_Y0:    return 64'(r_y0);
            S_Y1:    return 64'(r_y1);
            S_G0:    return 64'(r_g0);
            S_G1:    return 64'(r_g1);
            S_H:     return 64'(r_h);
            S_A:     return r_a;
            S_B:     return r_b;
            S_C:     return r_c;
            S_U:     return r_u;
            S_U2:    return r_u2;
            S_U3:    return r_u3;
            S_RES:   return r_res;
            S_K1:    return K_ONE;
            S_K2:    return K_TWO;
            S_K3:    return K_THREE;
            S_K4:    return K_FOUR;
            S_K6:    return K_SIX;
            default: return '0;
        endcase
    endfunction

    assign w_midx    = {r_var, r_mrk};
    assign w_offp    = r_wslot + 1'b1;
    assign w_wr_slot = (r_req == REQ_APPEND) ? w_offp : r_wslot;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_K:    w_rd_slot = r_k;
            RD_K1:   w_rd_slot = r_k1;
            default: w_rd_slot = r_wslot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            m_time[r_clr[SLOT_W-1:0]] <= '0;
            m_val[r_clr]              <= '0;
            m_slope[r_clr]            <= '0;
        end else if (i_cmd.wr_item) begin
            if (r_req == REQ_APPEND) m_time[w_wr_slot] <= r_t;
            m_val[{r_var, w_wr_slot}]   <= r_sv;
            m_slope[{r_var, w_wr_slot}] <= r_sg;
        end
        r_time_q  <= m_time[w_rd_slot];
        r_val_q   <= m_val[{r_var, w_rd_slot}];
        r_slope_q <= m_slope[{r_var, w_rd_slot}];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_wslot <= SLOT_W'(HIST_DEPTH - 1);
            r_busy  <= 1'b0;
            for (int i = 0; i < NUM_MIDX; i++) r_marks[i] <= '0;
        end else begin
            if (i_cmd.clear_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.wr_item && r_req == REQ_APPEND) r_wslot <= w_offp;
            if (i_cmd.mark_wr) r_marks[w_midx] <= r_k;
            if (i_cmd.alu_start) r_busy <= 1'b1;
            else if (w_alu_done) r_busy <= 1'b0;
        end
    end

    // item, walk and operand capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req_type;
            r_var <= i_var_index[VAR_W-1:0];
            r_mrk <= i_marker_index[MRK_W-1:0];
            r_t   <= i_when;
            r_sv  <= i_sample_value;
            r_sg  <= i_sample_slope;
            r_hit <= 1'b0;
        end
        if (i_cmd.set_hit) r_hit <= 1'b1;
        if (i_cmd.k_init) begin
            r_k  <= r_marks[w_midx];
            r_k1 <= r_marks[w_midx] + 1'b1;
        end
        if (i_cmd.k1_inc) r_k1 <= r_k1 + 1'b1;
        if (i_cmd.k_from_k1) r_k <= r_k1 - 1'b1;
        if (i_cmd.k_dec) r_k <= r_k - 1'b1;
        if (i_cmd.k1_from_k) r_k1 <= r_k + 1'b1;
        if (i_cmd.cap_lo) begin
            r_x0   <= r_time_q;
            r_y0   <= r_val_q;
            r_g0   <= r_slope_q;
            r_flag <= (r_t < r_time_q);
        end
        if (i_cmd.cap_hi) begin
            r_x1 <= r_time_q;
            r_y1 <= r_val_q;
            r_g1 <= r_slope_q;
            r_h  <= $signed({1'b0, r_time_q}) - $signed({1'b0, r_x0});
        end
        if (i_cmd.out_load) begin
            if (!r_req[1]) begin
                o_answer        <= '0;
                o_lag_too_large <= 1'b0;
            end else if (r_hit) begin
                o_answer        <= r_y0;
                o_lag_too_large <= 1'b0;
            end else begin
                o_answer        <= clamp32(r_res);
                o_lag_too_large <= r_flag;
            end
        end
    end

    // arithmetic unit: add/sub in one step, multiply over four partial
    // products, divide one quotient bit a step
    assign w_uop    = uop_rom(i_cmd.pc);
    assign w_step   = 2'(r_cnt - CNT_W'(1));
    assign w_pa     = w_step[1] ? r_ma[63:32] : r_ma[31:0];
    assign w_pb     = w_step[0] ? r_mb[63:32] : r_mb[31:0];
    assign w_prod   = w_pa * w_pb;
    assign w_dsh    = {r_drem, r_dnum[DIV_NW-1]};
    assign w_dtrial = w_dsh - {1'b0, r_dden};
    assign w_ca     = clamp40(r_opa);
    assign w_cb     = clamp40(r_opb);
    assign w_dmag_a = mag64(w_ca);
    assign w_dmag_b = mag64(w_cb);

    always_comb begin
        if (|r_acc[127:112]) w_mmag = SAT_LIM;
        else if (r_acc[111:16] > 96'(SAT_LIM)) w_mmag = SAT_LIM;
        else w_mmag = r_acc[79:16];
        case (r_uop.kind)
            UK_ADD:  w_alu_res = sat61(r_opa + r_opb);
            UK_SUB:  w_alu_res = sat61(r_opa - r_opb);
            UK_MUL:  w_alu_res = r_neg ? -$signed(w_mmag) : $signed(w_mmag);
            UK_DIV:  w_alu_res = r_dzero ? 64'sd0 :
                                 (r_neg ? -$signed(64'(r_dnum)) : $signed(64'(r_dnum)));
            default: w_alu_res = '0;
        endcase
        case (r_uop.kind)
            UK_MUL:  w_alu_done = r_busy && (r_cnt == MUL_DONE);
            UK_DIV:  w_alu_done = r_busy && (r_cnt == DIV_DONE);
            default: w_alu_done = r_busy;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alu_start) begin
            r_uop <= w_uop;
            r_opa <= sat61(src_val(w_uop.sa));
            r_opb <= sat61(src_val(w_uop.sb));
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_uop.kind == UK_MUL) begin
                if (r_cnt == '0) begin
                    r_neg <= r_opa[63] ^ r_opb[63];
                    r_ma  <= mag64(r_opa);
                    r_mb  <= mag64(r_opb);
                    r_acc <= '0;
                end
                if (r_cnt >= CNT_W'(1) && r_cnt <= CNT_W'(MUL_STEPS)) begin
                    r_pp  <= w_prod;
                    r_psh <= 2'(w_step[1] + w_step[0]);
                end
                if (r_cnt >= CNT_W'(2) && r_cnt <= CNT_W'(MUL_STEPS + 1))
                    r_acc <= r_acc + ({64'b0, r_pp} << {r_psh, 5'b0});
            end
            if (r_uop.kind == UK_DIV) begin
                if (r_cnt == '0) begin
                    r_dzero <= (r_opb == '0);
                    r_neg   <= w_ca[63] ^ w_cb[63];
                    r_dnum  <= {w_dmag_a[DIV_DW-1:0], 16'b0};
                    r_dden  <= w_dmag_b[DIV_DW-1:0];
                    r_drem  <= '0;
                end else if (r_cnt <= CNT_W'(DIV_NW)) begin
                    if (!w_dtrial[DIV_DW]) r_drem <= w_dtrial[DIV_DW-1:0];
                    else r_drem <= w_dsh[DIV_DW-1:0];
                    r_dnum <= {r_dnum[DIV_NW-2:0], ~w_dtrial[DIV_DW]};
                end
            end
        end
        if (w_alu_done) begin
            case (r_uop.dst)
                D_A:     r_a   <= w_alu_res;
                D_B:     r_b   <= w_alu_res;
                D_C:     r_c   <= w_alu_res;
                D_U:     r_u   <= w_alu_res;
                D_U2:    r_u2  <= w_alu_res;
                D_U3:    r_u3  <= w_alu_res;
                D_RES:   r_res <= w_alu_res;
                default: r_res <= w_alu_res;
            endcase
        end
    end

    assign o_stat.clear_last = &r_clr;
    assign o_stat.is_write   = ~r_req[1];
    assign o_stat.is_grad    = (r_req == REQ_QGRAD);
    assign o_stat.hit        = (r_req == REQ_QVAL) && (r_time_q == r_t);
    assign o_stat.w1_go      = (r_time_q < r_t) && (r_k1 != r_wslot);
    assign o_stat.w2_go      = (r_time_q > r_t) && (r_k != w_offp);
    assign o_stat.sw         = (r_t > r_x1) && (r_h == '0);
    assign o_stat.zi         = (r_h == '0);
    assign o_stat.alu_busy   = r_busy;
    assign o_stat.alu_done   = w_alu_done;

endmodule

FILE: rtl/core/timed_history_hermite_lookup.sv
// Timestamped sample history with cubic Hermite lookup, Q16.16.
//
// Input channel (i_in_valid / o_in_stall) carries one item: append a slot,
// store into the current slot, query a value or query a gradient. Output
// channel (o_out_valid / i_out_stall) returns one result item per input
// item: o_answer (zero for writes) and o_lag_too_large.
//
// One item is worked on at a time. A write reads and checks the newest slot
// and then writes; an exact value hit on the newest slot answers after that check.
// Other queries walk the ring up from the marker and back down, load the
// bracketing pair and run the evaluation on a shared arithmetic unit: add,
// multiply and divide (one quotient bit per cycle). A value query runs one divide, ten
// multiplies and nine adds; a gradient query two divides, nine multiplies
// and eight adds. The divider and the ring walk dominate the time of a
// query.
//
// After reset the block sweeps all 2048 entries of the sample memories to zero, one entry per
// cycle, holding o_in_stall high. The finished result sits in
// an output register; while the receiver stalls it holds, and the block
// takes the next item but will not overwrite the waiting result.
module timed_history_hermite_lookup import thhl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [2:0]         i_var_index,
    input  logic [1:0]         i_marker_index,
    input  logic [31:0]        i_when,
    input  logic signed [31:0] i_sample_value,
    input  logic signed [31:0] i_sample_slope,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_answer,
    output logic               o_lag_too_large
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: clear pass, ring walk, micro-program for the Hermite terms
    thhl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // memories, markers, operand registers and the arithmetic unit
    thhl_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_req_type      (i_req_type),
        .i_var_index     (i_var_index),
        .i_marker_index  (i_marker_index),
        .i_when          (i_when),
        .i_sample_value  (i_sample_value),
        .i_sample_slope  (i_sample_slope),
        .o_answer        (o_answer),
        .o_lag_too_large (o_lag_too_large)
    );

    // a new operation must never be issued while the unit is still busy
    a_alu_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.alu_start |-> !w_stat.alu_busy)
        else $error("arithmetic unit issued while busy");

    // an accepted item closes the input until its result is loaded into the output register
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item accepted while one is in flight");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(o_out_valid && i_out_stall))
        else $error("result register loaded while stalled");

endmodule

FILE: verif/tb_timed_history_hermite_lookup.sv
module tb_timed_history_hermite_lookup;
    import thhl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint LIM61 = 64'sh2000_0000_0000_0000;
    localparam longint QONE  = 65536;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_req_type;
    logic [2:0]         i_var_index;
    logic [1:0]         i_marker_index;
    logic [31:0]        i_when;
    logic signed [31:0] i_sample_value;
    logic signed [31:0] i_sample_slope;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_answer;
    logic               o_lag_too_large;

    timed_history_hermite_lookup dut (.*);

    // clock: 8 ns period
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // predictor copy of the history ring
    logic [31:0] ring_time [HIST_DEPTH];
    logic [31:0] ring_val  [NUM_VARS*HIST_DEPTH];
    logic [31:0] ring_slope[NUM_VARS*HIST_DEPTH];
    int unsigned newest_slot;
    int unsigned search_pos[NUM_MARKS*NUM_VARS];

    typedef struct {
        logic signed [31:0] answer;
        logic               lag;
    } t_result;

    t_result answers_due[$];
    int      mismatches;
    int      results_seen;
    int      queries_sent;
    int      lag_flags_seen;
    int      idle_pct_in;
    int      stall_pct_out;
    int      cycle_no = 0;
    int      hold_off_until;

    function automatic longint clip61(longint x);
        if (x > LIM61) return LIM61;
        if (x < -LIM61) return -LIM61;
        return x;
    endfunction

    function automatic longint qadd(longint a, longint b);
        return clip61(clip61(a) + clip61(b));
    endfunction

    // exact 128-bit product, truncate magnitude by 16, saturate
    function automatic longint qmul(longint a, longint b);
        logic [127:0] prod;
        logic [63:0]  ma, mb;
        logic         neg;
        longint       r;
        a = clip61(a);
        b = clip61(b);
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        prod = {64'd0, ma} * {64'd0, mb};
        if (prod[127:80] != 0) return neg ? -LIM61 : LIM61;
        r = longint'(prod[79:16]);
        if (prod[79:16] > 64'(LIM61)) r = LIM61;
        return neg ? -r : r;
    endfunction

    function automatic longint qdiv(longint a, longint b);
        longint      lim;
        logic [63:0] ua, ub, q;
        logic        neg;
        lim = 64'sd1 << 40;
        if (b == 0) return 0;
        if (a > lim) a = lim;
        if (a < -lim) a = -lim;
        if (b > lim) b = lim;
        if (b < -lim) b = -lim;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        q = (ua << 16) / ub;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [31:0] clip32(longint x);
        if (x > 64'sd2147483647) return 32'sh7fff_ffff;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic longint sx(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic void predict_reset();
        foreach (ring_time[i]) ring_time[i] = '0;
        foreach (ring_val[i]) ring_val[i] = '0;
        foreach (ring_slope[i]) ring_slope[i] = '0;
        foreach (search_pos[i]) search_pos[i] = 0;
        newest_slot = HIST_DEPTH - 1;
    endfunction

    // advance the ring copy by one item and return what the block must answer
    function automatic t_result hermite_lookup(logic [1:0] req, logic [2:0] vi,
                                               logic [1:0] mi, logic [31:0] t,
                                               logic [31:0] sv, logic [31:0] sg);
        t_result     r;
        int unsigned base, off, offp, k, k1, mix;
        longint      x0, x1, y0, y1, g0, g1, h, res, u, u2, u3, dy;
        longint      b01, b10, b11, p, w, d10, d11;
        r.answer = '0;
        r.lag = 1'b0;
        base = vi * HIST_DEPTH;
        off = newest_slot;
        if (req == REQ_APPEND || req == REQ_STORE) begin
            if (req == REQ_APPEND) begin
                off = (off + 1) % HIST_DEPTH;
                newest_slot = off;
                ring_time[off] = t;
            end
            ring_val[base+off] = sv;
            ring_slope[base+off] = sg;
            return r;
        end
        if (req == REQ_QVAL && ring_time[off] == t) begin
            r.answer = ring_val[base+off];
            return r;
        end
        mix = vi * NUM_MARKS + mi;
        offp = (off + 1) % HIST_DEPTH;
        k = search_pos[mix] % HIST_DEPTH;
        k1 = (k + 1) % HIST_DEPTH;
        while (ring_time[k1] < t && k1 != off) k1 = (k1 + 1) % HIST_DEPTH;
        k = (k1 == 0) ? HIST_DEPTH - 1 : k1 - 1;
        while (ring_time[k] > t && k != offp) k = (k == 0) ? HIST_DEPTH - 1 : k - 1;
        k1 = (k + 1) % HIST_DEPTH;
        r.lag = t < ring_time[k];
        x0 = longint'(ring_time[k]);
        x1 = longint'(ring_time[k1]);
        y0 = sx(ring_val[base+k]);
        y1 = sx(ring_val[base+k1]);
        g0 = sx(ring_slope[base+k]);
        g1 = sx(ring_slope[base+k1]);
        h = x1 - x0;
        if (longint'(t) > x1 && h == 0) begin
            // switch: extend linearly from the upper sample
            res = (req == REQ_QVAL) ? qadd(y1, qmul(longint'(t) - x1, g1)) : g1;
        end else if (h == 0) begin
            res = (req == REQ_QVAL) ? y0 : g0;
        end else begin
            u = qdiv(longint'(t) - x0, h);
            u2 = qmul(u, u);
            u3 = qmul(u2, u);
            dy = y1 - y0;
            if (req == REQ_QVAL) begin
                b01 = qadd(qmul(3 * QONE, u2), -qmul(2 * QONE, u3));
                b10 = qadd(qadd(u3, -qmul(2 * QONE, u2)), u);
                b11 = qadd(u3, -u2);
                res = qadd(y0, qmul(dy, b01));
                res = qadd(res, qmul(qmul(h, g0), b10));
                res = qadd(res, qmul(qmul(h, g1), b11));
            end else begin
                p = qdiv(dy, h);
                w = qmul(6 * QONE, qadd(u, -u2));
                d10 = qadd(qadd(qmul(3 * QONE, u2), -qmul(4 * QONE, u)), QONE);
                d11 = qadd(qmul(3 * QONE, u2), -qmul(2 * QONE, u));
                res = qadd(qmul(p, w), qmul(g0, d10));
                res = qadd(res, qmul(g1, d11));
            end
        end
        search_pos[mix] = k;
        r.answer = clip32(res);
        return r;
    endfunction

    // directed rows; known_ans marks rows whose result is typed in
    typedef struct {
        logic [1:0]  req;
        logic [2:0]  vi;
        logic [1:0]  mi;
        logic [31:0] t;
        logic [31:0] sv;
        logic [31:0] sg;
        logic        known_ans;
        logic [31:0] ans;
        logic        lag;
    } t_row;

    t_row directed_rows[] = '{
        // fresh ring: newest slot time is zero, so a value query at 0 hits
        '{REQ_QVAL,  3'd0, 2'd0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0},
        '{REQ_QGRAD, 3'd7, 2'd3, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0},
        '{REQ_APPEND, 3'd0, 2'd0, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
          1'b1, 32'h0, 1'b0},
        '{REQ_STORE, 3'd7, 2'd0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
          1'b1, 32'h0, 1'b0},
        '{REQ_APPEND, 3'd0, 2'd0, 32'h0003_0000, 32'h0006_0000, 32'h0000_8000,
          1'b1, 32'h0, 1'b0},
        '{REQ_STORE, 3'd7, 2'd0, 32'h0, 32'h7fff_ffff, 32'h8000_0000,
          1'b1, 32'h0, 1'b0},
        // exact newest hit
        '{REQ_QVAL, 3'd0, 2'd1, 32'h0003_0000, 32'h0, 32'h0, 1'b1, 32'h0006_0000, 1'b0},
        '{REQ_QVAL,  3'd0, 2'd1, 32'h0002_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{REQ_QGRAD, 3'd0, 2'd2, 32'h0002_8000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{REQ_QVAL,  3'd7, 2'd3, 32'h0001_8000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{REQ_QGRAD, 3'd7, 2'd3, 32'h0002_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
        // repeated time: zero interval and switch extrapolation
        '{REQ_APPEND, 3'd1, 2'd0, 32'h0003_0000, 32'hfffe_0000, 32'h0003_0000,
          1'b1, 32'h0, 1'b0},
        '{REQ_QVAL,  3'd1, 2'd0, 32'h0004_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{REQ_QGRAD, 3'd1, 2'd1, 32'h0005_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{REQ_QVAL,  3'd1, 2'd2, 32'hffff_ffff, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{REQ_QGRAD, 3'd0, 2'd3, 32'h0003_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
        // far past: older than everything stored
        '{REQ_QVAL,  3'd0, 2'd0, 32'h0000_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{REQ_QGRAD, 3'd7, 2'd0, 32'h0000_0001, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
        // huge gap saturates the answer
        '{REQ_APPEND, 3'd2, 2'd0, 32'hffff_0000, 32'h7fff_ffff, 32'h7fff_ffff,
          1'b1, 32'h0, 1'b0},
        '{REQ_QVAL,  3'd2, 2'd1, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{REQ_QGRAD, 3'd2, 2'd1, 32'hfff0_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0}
    };

    // one item to be offered
    typedef struct {
        logic [1:0]  req;
        logic [2:0]  vi;
        logic [1:0]  mi;
        logic [31:0] t;
        logic [31:0] sv;
        logic [31:0] sg;
    } t_item;

    // wait for acceptance of one item, with random sender gaps
    task automatic offer_item(t_item it);
        while (($urandom_range(99) < idle_pct_in)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= it.req;
        i_var_index    <= it.vi;
        i_marker_index <= it.mi;
        i_when         <= it.t;
        i_sample_value <= it.sv;
        i_sample_slope <= it.sg;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (it.req == REQ_QVAL || it.req == REQ_QGRAD) queries_sent++;
        answers_due.push_back(hermite_lookup(it.req, it.vi, it.mi, it.t, it.sv, it.sg));
    endtask

    // queries mostly land inside the written span of times
    logic [31:0] time_now;

    task automatic random_phase(int count);
        t_item it;
        int    sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            it.vi = 3'($urandom);
            it.mi = 2'($urandom);
            it.sv = $urandom;
            it.sg = $urandom;
            if (sel < 10) begin
                // small values keep Hermite results in range most of the time
                it.sv = $signed($urandom_range(2 << 16)) - (1 << 16);
                it.sg = $signed($urandom_range(2 << 16)) - (1 << 16);
            end
            if (sel < 35) begin
                it.req = REQ_APPEND;
                if ($urandom_range(9) != 0) time_now = time_now + $urandom_range(3 << 16);
                it.t = time_now;
            end else if (sel < 45) begin
                it.req = REQ_STORE;
                it.t = $urandom;
            end else begin
                it.req = $urandom_range(1) ? REQ_QVAL : REQ_QGRAD;
                case ($urandom_range(9))
                    0: it.t = $urandom;
                    1: it.t = time_now;
                    2: it.t = time_now + $urandom_range(1 << 18);
                    default: it.t = time_now - $urandom_range(40 << 16);
                endcase
            end
            if (i_rst_n) offer_item(it);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no < hold_off_until) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct_out);
        end
    end

    // checker: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result answer=%h", o_answer);
            end else begin
                want = answers_due.pop_front();
                if (want.lag) lag_flags_seen++;
                if (o_answer !== want.answer || o_lag_too_large !== want.lag) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: answer exp %h got %h, lag exp %b got %b",
                                 want.answer, o_answer, want.lag, o_lag_too_large);
                end
            end
        end
    end

    initial begin
        t_item it;
        mismatches = 0;
        results_seen = 0;
        queries_sent = 0;
        lag_flags_seen = 0;
        idle_pct_in = 0;
        stall_pct_out = 0;
        hold_off_until = 0;
        time_now = 32'h0003_0000;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = REQ_APPEND;
        i_var_index = '0;
        i_marker_index = '0;
        i_when = '0;
        i_sample_value = '0;
        i_sample_slope = '0;
        predict_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows; typed-in answers are checked against the predictor too
        foreach (directed_rows[i]) begin
            t_result guess;
            it = '{directed_rows[i].req, directed_rows[i].vi, directed_rows[i].mi,
                   directed_rows[i].t, directed_rows[i].sv, directed_rows[i].sg};
            offer_item(it);
            guess = answers_due[$];
            if (directed_rows[i].known_ans &&
                (guess.answer !== directed_rows[i].ans || guess.lag !== directed_rows[i].lag)) begin
                mismatches++;
                if (mismatches <= 10) $display("directed row %0d: table and predictor disagree", i);
            end
        end
        time_now = 32'hffff_0000;
        drain();

        // restart time base low so the ring wraps with increasing times
        time_now = 32'h0010_0000;
        random_phase(130);
        idle_pct_in = 68;
        random_phase(100);
        // sender pauses until every result is back
        drain();
        idle_pct_in = 0;
        stall_pct_out = 68;
        random_phase(100);
        idle_pct_in = 26;
        stall_pct_out = 26;
        random_phase(60);
        // long receiver hold-off while items keep coming
        idle_pct_in = 0;
        stall_pct_out = 0;
        hold_off_until = cycle_no + 600;
        random_phase(40);
        stall_pct_out = 26;
        random_phase(60);
        drain();
        repeat (300) @(posedge i_clk);

        $display("covered %0d results, %0d queries, %0d with the lag flag set",
                 results_seen, queries_sent, lag_flags_seen);
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("tb_timed_history_hermite_lookup: PASS");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches, answers_due.size());
            $display("tb_timed_history_hermite_lookup: FAIL");
        end
        $finish;
    end

    // timeout: ~500 items under heavy stalls
    initial begin
        #40ms;
        $display("timeout");
        $display("tb_timed_history_hermite_lookup: FAIL");
        $finish;
    end

endmodule
